[design/fr90_pkg.sv]
// Shared constants, types and helpers for the frame rotation block.
package fr90_pkg;

  // Frame geometry
  localparam int MAX_DIM    = 256;
  localparam int COORD_W    = $clog2(MAX_DIM);   // one coordinate
  localparam int DIM_W      = COORD_W + 1;       // a dimension, 1..MAX_DIM
  localparam int ADDR_W     = 2 * COORD_W;       // frame store address
  localparam int COUNT_W    = ADDR_W + 1;        // pixel count, up to MAX_DIM^2
  localparam int PIXEL_BITS = 24;
  localparam int PORT_PIX_W = 24;                // pixel ports

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 2'd3;
  localparam int CFG_DATA_W = 9;

  // Item functions
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Pixel modes
  localparam logic MODE_INDEX8 = 1'b0;
  localparam logic MODE_BGR24  = 1'b1;

  // Rotation codes, clockwise
  typedef enum logic [1:0] {
    ANGLE_0   = 2'd0,
    ANGLE_90  = 2'd1,
    ANGLE_180 = 2'd2,
    ANGLE_270 = 2'd3
  } angle_e;

  // Register file contents
  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    angle_e           angle_code;
    logic             pixel_mode;
  } cfg_t;

  // Work handed from the address generator to the store pipeline
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic                  last;
    logic                  mode;
    logic [COORD_W-1:0]    sx;
    logic [COORD_W-1:0]    sy;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PIXEL_BITS-1:0] data;
  } fetch_t;

  // Dimension forced into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Keep the bits the pixel mode stores
  function automatic logic [PIXEL_BITS-1:0] mask_pixel(input logic [PIXEL_BITS-1:0] p,
                                                       input logic mode);
    logic [PIXEL_BITS-1:0] r;
    if (mode == MODE_INDEX8) begin
      r = {{(PIXEL_BITS-8){1'b0}}, p[7:0]};
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

[design/frame_rotate_90_steps.sv]
// Top level: configuration registers, address stage, frame store and result stage.
//
//  channel   | signals                                         | direction
//  ----------+-------------------------------------------------+----------
//  command   | start, busy, func_i, pixel_in_i                 | in
//  result    | result_valid_o, pixel_out_o, last_of_frame_o    | out
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// One word is taken every cycle; busy stays low. A read word gives its pixel
// after the counter/mapping stage, the address multiply stage, then the
// registered frame store read (one port, one access a cycle).
// Load words and reads before the frame is full give no result.
// Reset clears the counters and pipeline valid bits and resets the config; the
// frame store is not cleared. Results cannot be held off by the receiver.
module frame_rotate_90_steps (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic [fr90_pkg::PORT_PIX_W-1:0] pixel_in_i,
  output logic                            result_valid_o,
  output logic [fr90_pkg::PORT_PIX_W-1:0] pixel_out_o,
  output logic                            last_of_frame_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fr90_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fr90_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fr90_pkg::*;

  cfg_t   cfg_q, cfg_d;
  fetch_t fetch;
  logic   take;

  logic                  wr_en2_q, rd_en2_q, rd_en3_q;
  logic                  last2_q, mode2_q, last3_q, mode3_q;
  logic [ADDR_W-1:0]     addr2_q, addr_d;
  logic [PIXEL_BITS-1:0] data2_q, rd_data_q;
  logic [DIM_W-1:0]      w;

  logic [PIXEL_BITS-1:0] frame_mem [2**ADDR_W];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign take        = start && !busy;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:  cfg_d.src_width  = DIM_W'(cfg_data_i);
        CFG_SRC_HEIGHT: cfg_d.src_height = DIM_W'(cfg_data_i);
        CFG_ANGLE_CODE: cfg_d.angle_code = angle_e'(cfg_data_i[1:0]);
        CFG_PIXEL_MODE: cfg_d.pixel_mode = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= DIM_W'(MAX_DIM);
      cfg_q.src_height <= DIM_W'(MAX_DIM);
      cfg_q.angle_code <= ANGLE_0;
      cfg_q.pixel_mode <= MODE_BGR24;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stage 1: counters and source coordinates
  fr90_addr_gen u_addr_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .take_i  (take),
    .func_i  (func_i),
    .pixel_i (pixel_in_i),
    .fetch_o (fetch)
  );

  // Stage 2: linear store address
  assign w = clamp_dim(cfg_q.src_width);

  always_comb begin
    if (fetch.wr_en) begin
      addr_d = fetch.wr_addr;
    end else begin
      addr_d = ADDR_W'(COUNT_W'(fetch.sy) * COUNT_W'(w) + COUNT_W'(fetch.sx));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en2_q <= 1'b0;
      rd_en2_q <= 1'b0;
      rd_en3_q <= 1'b0;
    end else begin
      wr_en2_q <= fetch.wr_en;
      rd_en2_q <= fetch.rd_en;
      rd_en3_q <= rd_en2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr2_q <= addr_d;
    data2_q <= fetch.data;
    last2_q <= fetch.last;
    mode2_q <= fetch.mode;
    last3_q <= last2_q;
    mode3_q <= mode2_q;
  end

  // Stage 3: frame store, one access a cycle in word order
  always_ff @(posedge clk_i) begin
    if (wr_en2_q) begin
      frame_mem[addr2_q] <= data2_q;
    end
    rd_data_q <= frame_mem[addr2_q];
  end

  // Result; the frame end flag only shows with a read result
  assign result_valid_o  = rd_en3_q;
  assign pixel_out_o     = PORT_PIX_W'(mask_pixel(rd_data_q, mode3_q));
  assign last_of_frame_o = last3_q && rd_en3_q;

endmodule

[design/fr90_addr_gen.sv]
// Load and destination counters, source coordinate mapping, first pipeline stage.
module fr90_addr_gen (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fr90_pkg::cfg_t                  cfg_i,
  input  logic                            take_i,
  input  logic                            func_i,
  input  logic [fr90_pkg::PORT_PIX_W-1:0] pixel_i,
  output fr90_pkg::fetch_t                fetch_o
);
  import fr90_pkg::*;

  logic [COUNT_W-1:0]    load_count_q, load_count_d;
  logic [COORD_W-1:0]    dest_x_q, dest_x_d;
  logic [COORD_W-1:0]    dest_y_q, dest_y_d;
  logic                  wr_en_q, wr_en_d;
  logic                  rd_en_q, rd_en_d;
  logic                  last_q, mode_q;
  logic [COORD_W-1:0]    sx_q, sy_q, sx, sy, x, y;
  logic [ADDR_W-1:0]     wr_addr_q;
  logic [PIXEL_BITS-1:0] data_q, data_in;

  logic [DIM_W-1:0]   w, h, dw, dh;
  logic [COUNT_W-1:0] total;
  logic               loaded, last, x_end;

  // Frame size and load state
  assign w      = clamp_dim(cfg_i.src_width);
  assign h      = clamp_dim(cfg_i.src_height);
  assign total  = COUNT_W'(w) * COUNT_W'(h);
  assign loaded = (load_count_q >= total);

  // Destination size swaps for quarter turns
  always_comb begin
    if (cfg_i.angle_code == ANGLE_90 || cfg_i.angle_code == ANGLE_270) begin
      dw = h;
      dh = w;
    end else begin
      dw = w;
      dh = h;
    end
  end

  // Destination position, held inside the current frame size
  assign x = (DIM_W'(dest_x_q) < dw) ? dest_x_q : COORD_W'(dw - DIM_W'(1));
  assign y = (DIM_W'(dest_y_q) < dh) ? dest_y_q : COORD_W'(dh - DIM_W'(1));

  // Source coordinate for this destination pixel
  always_comb begin
    unique case (cfg_i.angle_code)
      ANGLE_90: begin
        sx = y;
        sy = COORD_W'(h - DIM_W'(1) - DIM_W'(x));
      end
      ANGLE_180: begin
        sx = COORD_W'(w - DIM_W'(1) - DIM_W'(x));
        sy = COORD_W'(h - DIM_W'(1) - DIM_W'(y));
      end
      ANGLE_270: begin
        sx = COORD_W'(w - DIM_W'(1) - DIM_W'(y));
        sy = x;
      end
      default: begin
        sx = x;
        sy = y;
      end
    endcase
  end

  assign x_end   = (DIM_W'(x) == dw - DIM_W'(1));
  assign last    = x_end && (DIM_W'(y) == dh - DIM_W'(1));
  assign data_in = mask_pixel(PIXEL_BITS'(pixel_i), cfg_i.pixel_mode);

  // Counter updates per accepted word
  always_comb begin
    load_count_d = load_count_q;
    dest_x_d     = dest_x_q;
    dest_y_d     = dest_y_q;
    wr_en_d      = 1'b0;
    rd_en_d      = 1'b0;
    if (take_i && func_i == FUNC_LOAD && !loaded) begin
      wr_en_d      = 1'b1;
      load_count_d = load_count_q + COUNT_W'(1);
    end else if (take_i && func_i == FUNC_READ && loaded) begin
      rd_en_d = 1'b1;
      if (last) begin
        load_count_d = '0;
        dest_x_d     = '0;
        dest_y_d     = '0;
      end else if (x_end) begin
        dest_x_d = '0;
        dest_y_d = y + COORD_W'(1);
      end else begin
        dest_x_d = x + COORD_W'(1);
        dest_y_d = y;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      dest_x_q     <= '0;
      dest_y_q     <= '0;
      wr_en_q      <= 1'b0;
      rd_en_q      <= 1'b0;
    end else begin
      load_count_q <= load_count_d;
      dest_x_q     <= dest_x_d;
      dest_y_q     <= dest_y_d;
      wr_en_q      <= wr_en_d;
      rd_en_q      <= rd_en_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    last_q    <= last;
    mode_q    <= cfg_i.pixel_mode;
    sx_q      <= sx;
    sy_q      <= sy;
    wr_addr_q <= load_count_q[ADDR_W-1:0];
    data_q    <= data_in;
  end

  assign fetch_o.wr_en   = wr_en_q;
  assign fetch_o.rd_en   = rd_en_q;
  assign fetch_o.last    = last_q;
  assign fetch_o.mode    = mode_q;
  assign fetch_o.sx      = sx_q;
  assign fetch_o.sy      = sy_q;
  assign fetch_o.wr_addr = wr_addr_q;
  assign fetch_o.data    = data_q;

endmodule

[design/fr90_checker.sv]
// Port-level checks on the frame rotation block, bound to its top level.
module fr90_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            func_i,
  input logic                            result_valid_o,
  input logic                            last_of_frame_o
);
  import fr90_pkg::*;

  // The block never refuses a command word
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Frame end flag only rides on a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   last_of_frame_o |-> result_valid_o)
    else $error("last_of_frame without result");

  // Every result comes from an earlier read word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   result_valid_o |-> $past(start && !busy && func_i == FUNC_READ, 3))
    else $error("result without matching read word");

  // A load word never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (start && !busy && func_i == FUNC_LOAD) |-> ##3 !result_valid_o)
    else $error("result from load word");

endmodule

bind frame_rotate_90_steps fr90_checker u_fr90_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .func_i          (func_i),
  .result_valid_o  (result_valid_o),
  .last_of_frame_o (last_of_frame_o)
);

[tb/sv/frame_rotate_90_steps_test.sv]
// Self-checking testbench for the frame rotation block: loads frames, reads them back rotated.
`timescale 1ns / 1ps

module frame_rotate_90_steps_test;
  import fr90_pkg::*;

  localparam int          RANDOM_WORDS = 700;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          END_WAIT     = 1000;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          MAX_REPORTS  = 10;

  // One rotated pixel as the block should return it
  typedef struct packed {
    logic [PORT_PIX_W-1:0] pixel;
    logic                  last;
  } rot_pixel_t;

  // Frame store copy, counters and registers; predicts and checks rotated pixels
  class rotation_board;
    logic [PIXEL_BITS-1:0] frame_mem [MAX_DIM*MAX_DIM];
    logic [COUNT_W-1:0]    loaded_px;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    angle_e                angle;
    logic                  mode;
    rot_pixel_t            rotated_q [$];
    int unsigned           useful_words;
    int unsigned           faults;
    bit                    frame_closed;

    function new();
      loaded_px    = '0;
      col          = '0;
      row          = '0;
      width_reg    = DIM_W'(256);
      height_reg   = DIM_W'(256);
      angle        = ANGLE_0;
      mode         = MODE_BGR24;
      useful_words = 0;
      faults       = 0;
      frame_closed = 1'b0;
    endfunction

    function logic [DIM_W-1:0] dim_fit(input logic [DIM_W-1:0] v);
      return (v == '0) ? DIM_W'(1) : ((v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v);
    endfunction

    function logic [PIXEL_BITS-1:0] keep_bits(input logic [PIXEL_BITS-1:0] p);
      return p & ((mode == MODE_INDEX8) ? PIXEL_BITS'(8'hFF) : {PIXEL_BITS{1'b1}});
    endfunction

    function logic [COUNT_W-1:0] frame_total();
      logic [COUNT_W-1:0] w;
      logic [COUNT_W-1:0] h;
      w = COUNT_W'(dim_fit(width_reg));
      h = COUNT_W'(dim_fit(height_reg));
      return w * h;
    endfunction

    function bit frame_full();
      return loaded_px >= frame_total();
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction

    function void note_fault(input string msg);
      faults++;
      if (faults <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SRC_WIDTH:  width_reg  = data;
        CFG_SRC_HEIGHT: height_reg = data;
        CFG_ANGLE_CODE: angle      = angle_e'(data[1:0]);
        CFG_PIXEL_MODE: mode       = data[0];
        default: ;
      endcase
    endfunction

    // Accepted word: store a pixel, or work out the next rotated pixel
    function void rotate_word(input logic f, input logic [PORT_PIX_W-1:0] p);
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
      logic [DIM_W-1:0]   dw;
      logic [DIM_W-1:0]   dh;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [ADDR_W-1:0]  addr;
      rot_pixel_t         item;
      w = dim_fit(width_reg);
      h = dim_fit(height_reg);
      if (f == FUNC_LOAD) begin
        if (!frame_full()) begin
          frame_mem[loaded_px[ADDR_W-1:0]] = keep_bits(p);
          loaded_px = loaded_px + 1'b1;
          useful_words++;
        end
        return;
      end
      // read before the frame is complete: nothing comes back
      if (!frame_full()) return;
      if (angle == ANGLE_90 || angle == ANGLE_270) begin
        dw = h;
        dh = w;
      end else begin
        dw = w;
        dh = h;
      end
      // position held over a config change is pulled back inside the frame
      x = (DIM_W'(col) < dw) ? col : COORD_W'(dw - 1'b1);
      y = (DIM_W'(row) < dh) ? row : COORD_W'(dh - 1'b1);
      case (angle)
        ANGLE_90: begin
          sx = y;
          sy = COORD_W'(h - 1'b1 - DIM_W'(x));
        end
        ANGLE_180: begin
          sx = COORD_W'(w - 1'b1 - DIM_W'(x));
          sy = COORD_W'(h - 1'b1 - DIM_W'(y));
        end
        ANGLE_270: begin
          sx = COORD_W'(w - 1'b1 - DIM_W'(y));
          sy = x;
        end
        default: begin
          sx = x;
          sy = y;
        end
      endcase
      addr = ADDR_W'(sy) * ADDR_W'(w) + ADDR_W'(sx);
      item.pixel = keep_bits(frame_mem[addr]);
      item.last  = (DIM_W'(x) == dw - 1'b1) && (DIM_W'(y) == dh - 1'b1);
      rotated_q.push_back(item);
      useful_words++;
      // advance in destination raster order
      if (item.last) begin
        loaded_px    = '0;
        col          = '0;
        row          = '0;
        frame_closed = 1'b1;
      end else if (DIM_W'(x) + 1'b1 >= dw) begin
        col = '0;
        row = y + 1'b1;
      end else begin
        col = x + 1'b1;
        row = y;
      end
    endfunction

    // Result off the strobe against the oldest predicted pixel
    function void check_pixel(input logic [PORT_PIX_W-1:0] pix, input logic last);
      rot_pixel_t exp;
      if (rotated_q.size() == 0) begin
        note_fault($sformatf("unexpected result: pixel_out %06h last_of_frame %0b", pix, last));
        return;
      end
      exp = rotated_q.pop_front();
      if (pix !== exp.pixel)
        note_fault($sformatf("pixel_out mismatch: expected %06h, got %06h", exp.pixel, pix));
      if (last !== exp.last)
        note_fault($sformatf("last_of_frame mismatch: expected %0b, got %0b", exp.last, last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  func_in;
  logic [PORT_PIX_W-1:0] pixel_in;
  logic                  result_valid;
  logic [PORT_PIX_W-1:0] pixel_out;
  logic                  last_of_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rotation_board board;
  int unsigned   idle_pct;
  int unsigned   cycle_count = 0;

  frame_rotate_90_steps dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_in),
    .pixel_in_i      (pixel_in),
    .result_valid_o  (result_valid),
    .pixel_out_o     (pixel_out),
    .last_of_frame_o (last_of_frame),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frame_rotate_90_steps_test: done, errors");
      $finish;
    end
  end

  // Monitor: results, accepted words and register writes, all at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid) board.check_pixel(pixel_out, last_of_frame);
      if (start && !busy) board.rotate_word(func_in, pixel_in);
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic logic [PORT_PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PORT_PIX_W'($urandom);
  endfunction

  // Register data with random bits above the ones the register keeps
  function automatic logic [CFG_DATA_W-1:0] pad_upper(input int unsigned value,
                                                      input int unsigned low_bits);
    logic [CFG_DATA_W-1:0] keep;
    keep = CFG_DATA_W'((1 << low_bits) - 1);
    return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
  endfunction

  // One command word; called and returns at a falling edge, start left high
  task automatic send_word(input logic f, input logic [PORT_PIX_W-1:0] p);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start    = 1'b1;
    func_in  = f;
    pixel_in = p;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Register write over the config channel
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Wait for the block to go idle: all pixels back, load words flushed
  task automatic settle();
    start = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // New frame geometry, mostly small, sometimes zero or oversized dimensions
  task automatic configure_frame();
    int unsigned           r;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    r = $urandom_range(99);
    if (r < 2) begin
      w = CFG_DATA_W'($urandom_range(511, 256));
      h = CFG_DATA_W'($urandom_range(2, 1));
    end else if (r < 4) begin
      w = CFG_DATA_W'($urandom_range(2, 1));
      h = CFG_DATA_W'($urandom_range(511, 256));
    end else if (r < 8) begin
      w = CFG_DATA_W'($urandom_range(3, 0));
      h = (w == '0) ? CFG_DATA_W'($urandom_range(4, 0)) : '0;
    end else begin
      w = CFG_DATA_W'($urandom_range(8, 1));
      h = CFG_DATA_W'($urandom_range(8, 1));
    end
    settle();
    cfg_write(CFG_SRC_WIDTH, w);
    cfg_write(CFG_SRC_HEIGHT, h);
    if ($urandom_range(9) < 7) cfg_write(CFG_ANGLE_CODE, pad_upper($urandom_range(3), 2));
    if ($urandom_range(9) < 7) cfg_write(CFG_PIXEL_MODE, pad_upper($urandom_range(1), 1));
  endtask

  // Load and read one frame until its last pixel, with stray words mixed in
  task automatic run_frame(input bit allow_changes);
    int unsigned roll;
    board.frame_closed = 1'b0;
    while (!board.frame_closed) begin
      roll = $urandom_range(99);
      if (!board.frame_full()) begin
        if (roll < 4) send_word(FUNC_READ, rand_pixel());
        else send_word(FUNC_LOAD, rand_pixel());
      end else if (allow_changes && roll < 2) begin
        // register change in the middle of the read-out
        settle();
        case ($urandom_range(3))
          0: cfg_write(CFG_SRC_WIDTH, CFG_DATA_W'($urandom_range(8, 1)));
          1: cfg_write(CFG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(8, 1)));
          2: cfg_write(CFG_ANGLE_CODE, pad_upper($urandom_range(3), 2));
          default: cfg_write(CFG_PIXEL_MODE, pad_upper($urandom_range(1), 1));
        endcase
      end else if (roll < 6) begin
        send_word(FUNC_LOAD, rand_pixel());
      end else begin
        send_word(FUNC_READ, rand_pixel());
      end
    end
  endtask

  // Stimulus
  initial begin
    int unsigned base;
    board     = new();
    rst_ni    = 1'b0;
    start     = 1'b0;
    func_in   = FUNC_LOAD;
    pixel_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SRC_WIDTH;
    cfg_data  = '0;
    idle_pct  = 8;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero sizes mean one pixel; early read gives nothing, surplus load dropped
    settle();
    cfg_write(CFG_SRC_WIDTH, '0);
    cfg_write(CFG_SRC_HEIGHT, '0);
    cfg_write(CFG_ANGLE_CODE, pad_upper(ANGLE_180, 2));
    cfg_write(CFG_PIXEL_MODE, pad_upper(MODE_BGR24, 1));
    send_word(FUNC_READ, 24'h5A5A5A);
    send_word(FUNC_LOAD, 24'hFFFFFF);
    send_word(FUNC_LOAD, 24'h000000);
    send_word(FUNC_READ, '0);

    // 3x2 frame at 90 degrees in index mode: upper bytes dropped
    settle();
    cfg_write(CFG_SRC_WIDTH, CFG_DATA_W'(3));
    cfg_write(CFG_SRC_HEIGHT, CFG_DATA_W'(2));
    cfg_write(CFG_ANGLE_CODE, pad_upper(ANGLE_90, 2));
    cfg_write(CFG_PIXEL_MODE, pad_upper(MODE_INDEX8, 1));
    send_word(FUNC_LOAD, 24'hFFFFFF);
    repeat (4) send_word(FUNC_LOAD, PORT_PIX_W'($urandom));
    send_word(FUNC_LOAD, 24'h000000);
    repeat (6) send_word(FUNC_READ, rand_pixel());

    // 3x1 frame switched to 270 degrees mid read-out: position clamps
    settle();
    cfg_write(CFG_SRC_WIDTH, CFG_DATA_W'(3));
    cfg_write(CFG_SRC_HEIGHT, CFG_DATA_W'(1));
    cfg_write(CFG_ANGLE_CODE, pad_upper(ANGLE_0, 2));
    cfg_write(CFG_PIXEL_MODE, pad_upper(MODE_BGR24, 1));
    repeat (3) send_word(FUNC_LOAD, PORT_PIX_W'($urandom));
    repeat (2) send_word(FUNC_READ, rand_pixel());
    settle();
    cfg_write(CFG_ANGLE_CODE, pad_upper(ANGLE_270, 2));
    repeat (3) send_word(FUNC_READ, rand_pixel());

    // one full-width row, width given above the maximum
    settle();
    cfg_write(CFG_SRC_WIDTH, '1);
    cfg_write(CFG_SRC_HEIGHT, CFG_DATA_W'(1));
    cfg_write(CFG_ANGLE_CODE, pad_upper($urandom_range(3), 2));
    cfg_write(CFG_PIXEL_MODE, pad_upper(MODE_BGR24, 1));
    run_frame(1'b0);

    // random frames; sender idles rarely, then often, then not at all
    base = board.useful_words;
    while (board.useful_words - base < RANDOM_WORDS) begin
      if (board.useful_words - base < RANDOM_WORDS / 3) idle_pct = 8;
      else if (board.useful_words - base < 2 * RANDOM_WORDS / 3) idle_pct = 70;
      else idle_pct = 0;
      configure_frame();
      run_frame(1'b1);
    end

    // drain and wrap up
    start = 1'b0;
    for (int n = 0; n < END_WAIT && board.pending() != 0; n++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (board.pending() != 0)
      board.note_fault($sformatf("%0d expected pixels never came back", board.pending()));
    if (board.faults == 0) begin
      $display("frame_rotate_90_steps_test: done, clean");
    end else begin
      $display("frame_rotate_90_steps_test: done, errors");
    end
    $finish;
  end

endmodule
